// ===== rtl/ema_ribbon_crossover_signal_core_macros.svh =====
// ----------------------------------------------------------------------------
// EMA ribbon crossover assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EMA_RIBBON_CROSSOVER_SIGNAL_CORE_MACROS_SVH
`define EMA_RIBBON_CROSSOVER_SIGNAL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ercs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ERCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ercs assertion failed");

`endif

// ===== rtl/ercs_pkg.sv =====
// ----------------------------------------------------------------------------
// EMA ribbon crossover package
// Types, register indexes, opcodes and reset values shared by the block.
// ----------------------------------------------------------------------------
package ercs_pkg;

  localparam int ALPHA_REGS = 5;
  localparam int MAX_OUT    = 5;
  localparam int LANE_W     = 3;
  localparam int PRICE_W    = 32;
  localparam int ALPHA_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LAST   = 3'd5;

  localparam logic OP_SEED   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic SIG_SELL = 1'b0;
  localparam logic SIG_BUY  = 1'b1;

  localparam logic [LANE_W-1:0] ACTIVE_RESET = 3'd5;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET [ALPHA_REGS] = '{
    16'd21845, 16'd11916, 16'd6242, 16'd2570, 16'd1298
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_REF,
    S_MUL,
    S_ACC
  } state_t;

endpackage

// ===== rtl/ercs_in_if.sv =====
// ----------------------------------------------------------------------------
// EMA ribbon crossover input channel
// Valid/ready channel carrying one price request.
// ----------------------------------------------------------------------------
interface ercs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] price;

  modport source (output valid, output opcode, output price, input ready);
  modport sink (input valid, input opcode, input price, output ready);
endinterface

// ===== rtl/ercs_out_if.sv =====
// ----------------------------------------------------------------------------
// EMA ribbon crossover result channel
// Valid/ready channel carrying one lane result per active lane of an update request.
// ----------------------------------------------------------------------------
interface ercs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  lane;
  logic [31:0] average;
  logic        signal;
  logic        last;

  modport source (output valid, output lane, output average, output signal,
                  output last, input ready);
  modport sink (input valid, input lane, input average, input signal,
                input last, output ready);
endinterface

// ===== rtl/ema_ribbon_crossover_signal_core.sv =====
// A seed request is taken in S_IDLE; an update steps through S_REF, then S_MUL and S_ACC for each of N active lanes.
// Requests are handled one at a time; a new one is accepted once the last result of an update is registered.
// Each lane passes through S_MUL and S_ACC, using the single shared blend multiplier and its output register.
// A stalled result register holds the sequencer in place until the result is taken.
// Reset (rst, synchronous) clears averages and signals, loads register defaults, empties output.
// ----------------------------------------------------------------------------
// EMA ribbon crossover signal core
// Keeps a ribbon of exponential moving averages and emits a crossover signal per lane.
// ----------------------------------------------------------------------------
`include "ema_ribbon_crossover_signal_core_macros.svh"

module ema_ribbon_crossover_signal_core #(
  parameter int LANES = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ercs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ercs_pkg::CFG_DATA_W-1:0]   cfg_data,
  ercs_in_if.sink                           in_ch,
  ercs_out_if.source                        out_ch
);

  localparam int USED  = (LANES < ercs_pkg::MAX_OUT) ? LANES : ercs_pkg::MAX_OUT;
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
  localparam logic [ercs_pkg::LANE_W-1:0] USED_N = ercs_pkg::LANE_W'(USED);

  ercs_pkg::state_t state, state_next;

  logic [31:0] avg [USED];
  logic        sig0;
  logic        prev_sig;
  logic [15:0] alpha [ercs_pkg::ALPHA_REGS];
  logic [2:0]  active_count;

  logic [31:0] price_q;
  logic [31:0] ref_avg;
  logic [2:0]  n_q;
  logic [2:0]  lane_q;

  logic        out_valid;
  logic [2:0]  out_lane;
  logic [31:0] out_average;
  logic        out_signal;
  logic        out_last;

  logic        in_fire;
  logic        load;
  logic        emit;
  logic        out_free;
  logic        is_last;
  logic [2:0]  n_eff;
  logic [2:0]  alpha_sel;
  logic [31:0] blend_new;
  logic        sig;

  always_comb begin
    if (active_count == 3'd0) begin
      n_eff = 3'd1;
    end else if (active_count > USED_N) begin
      n_eff = USED_N;
    end else begin
      n_eff = active_count;
    end
  end

  assign in_fire   = in_ch.valid & in_ch.ready;
  assign out_free  = ~out_valid | out_ch.ready;
  assign is_last   = (lane_q == n_q - 3'd1);
  assign alpha_sel = cfg_index - ercs_pkg::REG_ALPHA_FIRST;

  always_comb begin
    if (is_last) begin
      sig = ~(ref_avg > blend_new);
    end else if (ref_avg > blend_new) begin
      sig = ercs_pkg::SIG_SELL;
    end else if (ref_avg < blend_new) begin
      sig = ercs_pkg::SIG_BUY;
    end else if (lane_q == 3'd0) begin
      sig = sig0;
    end else begin
      sig = prev_sig;
    end
  end

  ercs_blend u_blend (
    .clk    (clk),
    .load   (load),
    .price  (price_q),
    .old    (avg[lane_q[IDX_W-1:0]]),
    .alpha  (alpha[lane_q]),
    .result (blend_new)
  );

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    load        = 1'b0;
    emit        = 1'b0;
    case (state)
      ercs_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.opcode == ercs_pkg::OP_UPDATE) begin
          state_next = ercs_pkg::S_REF;
        end
      end
      ercs_pkg::S_REF: begin
        state_next = ercs_pkg::S_MUL;
      end
      ercs_pkg::S_MUL: begin
        load       = 1'b1;
        state_next = ercs_pkg::S_ACC;
      end
      ercs_pkg::S_ACC: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = is_last ? ercs_pkg::S_IDLE : ercs_pkg::S_MUL;
        end
      end
      default: begin
        state_next = ercs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ercs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ercs_pkg::ACTIVE_RESET;
      for (int i = 0; i < ercs_pkg::ALPHA_REGS; i++) begin
        alpha[i] <= ercs_pkg::ALPHA_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == ercs_pkg::REG_ACTIVE_COUNT) begin
        active_count <= cfg_data[2:0];
      end else if (cfg_index <= ercs_pkg::REG_ALPHA_LAST) begin
        alpha[alpha_sel] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USED; i++) begin
        avg[i] <= '0;
      end
      sig0     <= ercs_pkg::SIG_SELL;
      prev_sig <= ercs_pkg::SIG_SELL;
      lane_q   <= '0;
      n_q      <= 3'd1;
    end else begin
      if (in_fire) begin
        price_q <= in_ch.price;
        n_q     <= n_eff;
        lane_q  <= '0;
        if (in_ch.opcode == ercs_pkg::OP_SEED) begin
          for (int i = 0; i < USED; i++) begin
            avg[i] <= in_ch.price;
          end
        end
      end
      if (state == ercs_pkg::S_REF) begin
        ref_avg <= avg[n_q[IDX_W-1:0] - IDX_W'(1)];
      end
      if (emit) begin
        avg[lane_q[IDX_W-1:0]] <= blend_new;
        prev_sig <= sig;
        if (lane_q == 3'd0) begin
          sig0 <= sig;
        end
        if (!is_last) begin
          lane_q <= lane_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_lane    <= lane_q;
      out_average <= blend_new;
      out_signal  <= sig;
      out_last    <= is_last;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.lane    = out_lane;
  assign out_ch.average = out_average;
  assign out_ch.signal  = out_signal;
  assign out_ch.last    = out_last;

  `ERCS_ASSERT_NEXT(a_update_starts, in_fire && in_ch.opcode == ercs_pkg::OP_UPDATE, state == ercs_pkg::S_REF)
  `ERCS_ASSERT_SAME(a_lane_in_range, state != ercs_pkg::S_IDLE, lane_q < n_q)
  `ERCS_ASSERT_SAME(a_last_lane, out_valid && out_last, out_lane == n_q - 3'd1)
  `ERCS_ASSERT_NEXT(a_seed_loads, in_fire && in_ch.opcode == ercs_pkg::OP_SEED, avg[0] == $past(in_ch.price))

endmodule

// ===== rtl/ercs_blend.sv =====
// ----------------------------------------------------------------------------
// EMA ribbon crossover blend unit
// Shared multiplier: new = old + ((price - old) * alpha) >>> 16, one lane per use.
// ----------------------------------------------------------------------------
module ercs_blend (
  input  logic                             clk,
  input  logic                             load,
  input  logic [ercs_pkg::PRICE_W-1:0]     price,
  input  logic [ercs_pkg::PRICE_W-1:0]     old,
  input  logic [ercs_pkg::ALPHA_W-1:0]     alpha,
  output logic [ercs_pkg::PRICE_W-1:0]     result
);

  logic signed [32:0] diff;
  logic signed [17:0] alpha_s;
  logic signed [50:0] prod;
  logic signed [50:0] prod_sh;
  logic [31:0]        old_q;

  assign diff    = $signed({1'b0, price}) - $signed({1'b0, old});
  assign alpha_s = $signed({2'b00, alpha});

  always_ff @(posedge clk) begin
    if (load) begin
      prod  <= 51'(diff) * 51'(alpha_s);
      old_q <= old;
    end
  end

  assign prod_sh = prod >>> 16;
  assign result  = old_q + prod_sh[31:0];

endmodule
